// File: src/mtrh_pkg.sv
// shared types and constants for the read holding registers server
package mtrh_pkg;

  localparam int AduBytesDef = 260;
  localparam int HdrKeep     = 12;
  localparam int JobMax      = 11;

  // input item codes
  localparam logic [1:0] FUNC_BYTE   = 2'd0;
  localparam logic [1:0] FUNC_STATUS = 2'd1;
  localparam logic [1:0] FUNC_WORD   = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [7:0] FN_READ     = 8'h03;
  localparam logic [7:0] EX_FUNCTION = 8'h01;
  localparam logic [7:0] EX_VALUE    = 8'h03;
  localparam logic [7:0] EX_FLAG     = 8'h80;
  localparam logic [15:0] READ_LEN_FIELD = 16'd6;
  localparam logic [15:0] MAX_REGS   = 16'd125;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STATUS,
    PH_WORDS
  } phase_e;

  // results caused by one transaction, handed to the emitter
  typedef struct packed {
    logic [3:0]               nbytes;
    logic                     has_req;
    logic [JobMax-1:0]        last;
    logic [JobMax-1:0][7:0]   data;
    logic [15:0]              start;
    logic [6:0]               count;
    logic [15:0]              requests;
    logic [15:0]              responses;
    logic [15:0]              exceptions;
    logic [15:0]              malformed;
  } job_t;

endpackage

// File: src/mtrh_ram.sv
// generic single write port ram with registered read
module mtrh_ram #(
  parameter int Width = 8,
  parameter int Depth = 260
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/mtrh_ctrl.sv
// ring control, header check and response job builder
module mtrh_ctrl #(
  parameter int AduBytes = mtrh_pkg::AduBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [1:0]                  func_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic [7:0]                  status_code_i,
  input  logic [15:0]                 reg_value_i,
  output logic                        refill_busy_o,
  output logic                        ram_we_o,
  output logic [$clog2(AduBytes)-1:0] ram_waddr_o,
  output logic [7:0]                  ram_wdata_o,
  output logic [$clog2(AduBytes)-1:0] ram_raddr_o,
  input  logic [7:0]                  ram_rdata_i,
  output mtrh_pkg::job_t              job_o
);

  localparam int PtrW  = $clog2(AduBytes);
  localparam int FillW = $clog2(AduBytes + 1);
  localparam int SumW  = FillW + 1;
  localparam logic [SumW-1:0] AduS = SumW'(AduBytes);

  logic [mtrh_pkg::HdrKeep-1:0][7:0] hdr_q, hdr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [PtrW-1:0]  head_q, head_d;
  mtrh_pkg::phase_e phase_q, phase_d;
  logic [15:0] trans_q, trans_d;
  logic [7:0]  unit_q, unit_d;
  logic [6:0]  pend_q, pend_d, left_q, left_d;
  logic [15:0] req_q, req_d, resp_q, resp_d, exc_q, exc_d, mal_q, mal_d;
  logic [3:0]  rd_idx_q, rd_idx_d, ref_tot_q, ref_tot_d, slot_q, slot_d;
  logic        rsp_q, rsp_d;

  // combinational working values
  logic [mtrh_pkg::HdrKeep-1:0][7:0] hdr_w;
  logic [FillW-1:0] fill_w, fill_rest;
  logic        do_check, word_on, hdr_on, ex_on, req_on, fin;
  logic [7:0]  ex_fc, ex_code;
  logic [15:0] proto, lenf, cnt, lf;
  logic [16:0] expect_len;
  logic [10:0] resp_len;
  logic [SumW-1:0] wsum, rsum, hsum;
  logic [3:0]  base;
  logic [8:0][7:0] eb;

  // ring addressing
  always_comb begin
    wsum = SumW'(head_q) + SumW'(fill_q);
    if (wsum >= AduS) wsum = wsum - AduS;
    rsum = SumW'(head_q) + SumW'(rd_idx_q);
    if (rsum >= AduS) rsum = rsum - AduS;
  end

  assign ram_waddr_o   = wsum[PtrW-1:0];
  assign ram_raddr_o   = rsum[PtrW-1:0];
  assign ram_wdata_o   = rx_byte_i;
  assign refill_busy_o = (rd_idx_q != ref_tot_q) || rsp_q;

  // next state and job
  always_comb begin
    hdr_w   = hdr_q;
    fill_w  = fill_q;
    head_d  = head_q;
    phase_d = phase_q;
    trans_d = trans_q;
    unit_d  = unit_q;
    pend_d  = pend_q;
    left_d  = left_q;
    req_d   = req_q;
    resp_d  = resp_q;
    exc_d   = exc_q;
    mal_d   = mal_q;
    rd_idx_d  = rd_idx_q;
    ref_tot_d = ref_tot_q;
    slot_d    = slot_q;
    rsp_d     = 1'b0;
    ram_we_o  = 1'b0;
    do_check  = 1'b0;
    word_on   = 1'b0;
    hdr_on    = 1'b0;
    ex_on     = 1'b0;
    req_on    = 1'b0;
    fin       = 1'b0;
    ex_fc     = 8'h00;
    ex_code   = 8'h00;
    proto     = 16'h0;
    lenf      = 16'h0;
    cnt       = 16'h0;
    expect_len = 17'h0;
    fill_rest  = '0;
    hsum       = '0;
    resp_len  = 11'd9 + 11'({pend_q, 1'b0});
    lf        = 16'd3 + 16'({pend_q, 1'b0});
    job_o     = '0;

    // header refill from the ring, one byte per cycle
    if (rd_idx_q != ref_tot_q) begin
      rd_idx_d = rd_idx_q + 4'd1;
      rsp_d    = 1'b1;
      slot_d   = rd_idx_q;
    end
    if (rsp_q) begin
      hdr_w[slot_q] = ram_rdata_i;
    end

    // accepted transaction
    if (accept_i) begin
      unique case (func_i)
        mtrh_pkg::FUNC_BYTE: begin
          if (fill_q == FillW'(AduBytes)) begin
            fill_w = '0;
            head_d = '0;
            mal_d  = mal_q + 16'd1;
          end else begin
            ram_we_o = 1'b1;
            if (fill_q < FillW'(mtrh_pkg::HdrKeep)) begin
              hdr_w[fill_q[3:0]] = rx_byte_i;
            end
            fill_w   = fill_q + FillW'(1);
            do_check = 1'b1;
          end
        end
        mtrh_pkg::FUNC_STATUS: begin
          if (phase_q == mtrh_pkg::PH_STATUS) begin
            if (status_code_i != 8'h00) begin
              ex_on   = 1'b1;
              ex_fc   = mtrh_pkg::FN_READ;
              ex_code = status_code_i;
            end else if (resp_len > 11'(AduBytes)) begin
              ex_on   = 1'b1;
              ex_fc   = mtrh_pkg::FN_READ;
              ex_code = mtrh_pkg::EX_VALUE;
            end else begin
              hdr_on  = 1'b1;
              resp_d  = resp_q + 16'd1;
              left_d  = pend_q;
              phase_d = mtrh_pkg::PH_WORDS;
            end
          end
        end
        mtrh_pkg::FUNC_WORD: begin
          if (phase_q == mtrh_pkg::PH_WORDS) begin
            word_on = 1'b1;
            fin     = (left_q <= 7'd1);
            if (fin) begin
              left_d   = '0;
              phase_d  = mtrh_pkg::PH_IDLE;
              do_check = 1'b1;
            end else begin
              left_d = left_q - 7'd1;
            end
          end
        end
        default: ;
      endcase
    end

    // frame check on the header at the ring head
    if (do_check && phase_d == mtrh_pkg::PH_IDLE &&
        fill_w >= FillW'(mtrh_pkg::HdrKeep - 5)) begin
      proto      = {hdr_w[2], hdr_w[3]};
      lenf       = {hdr_w[4], hdr_w[5]};
      expect_len = 17'd6 + 17'(lenf);
      if (proto != 16'h0 || lenf < 16'd2 || expect_len > 17'(AduBytes)) begin
        fill_w = '0;
        head_d = '0;
        mal_d  = mal_q + 16'd1;
      end else if (17'(fill_w) >= expect_len) begin
        trans_d = {hdr_w[0], hdr_w[1]};
        unit_d  = hdr_w[6];
        req_d   = req_q + 16'd1;
        cnt     = {hdr_w[10], hdr_w[11]};
        if (hdr_w[7] != mtrh_pkg::FN_READ) begin
          ex_on   = 1'b1;
          ex_fc   = hdr_w[7];
          ex_code = mtrh_pkg::EX_FUNCTION;
        end else if (lenf != mtrh_pkg::READ_LEN_FIELD) begin
          ex_on   = 1'b1;
          ex_fc   = hdr_w[7];
          ex_code = mtrh_pkg::EX_VALUE;
        end else if (cnt == 16'h0 || cnt > mtrh_pkg::MAX_REGS) begin
          ex_on   = 1'b1;
          ex_fc   = hdr_w[7];
          ex_code = mtrh_pkg::EX_VALUE;
        end else begin
          req_on  = 1'b1;
          pend_d  = cnt[6:0];
          phase_d = mtrh_pkg::PH_STATUS;
        end
        // drop the frame and, if bytes remain, reload the header of the next one
        if (expect_len >= 17'(fill_w)) begin
          fill_w = '0;
          head_d = '0;
        end else begin
          fill_rest = fill_w - expect_len[FillW-1:0];
          hsum = SumW'(head_q) + SumW'(expect_len[FillW-1:0]);
          if (hsum >= AduS) hsum = hsum - AduS;
          head_d    = hsum[PtrW-1:0];
          fill_w    = fill_rest;
          rd_idx_d  = '0;
          ref_tot_d = (fill_rest >= FillW'(mtrh_pkg::HdrKeep)) ?
                      4'(mtrh_pkg::HdrKeep) : fill_rest[3:0];
        end
      end
    end

    if (ex_on) begin
      exc_d   = exc_q + 16'd1;
      resp_d  = resp_q + 16'd1;
      phase_d = mtrh_pkg::PH_IDLE;
    end

    fill_d = fill_w;
    hdr_d  = hdr_w;

    // job assembly
    base = word_on ? 4'd2 : 4'd0;
    if (word_on) begin
      job_o.data[0] = reg_value_i[15:8];
      job_o.data[1] = reg_value_i[7:0];
      job_o.last[1] = fin;
    end
    eb[0] = trans_d[15:8];
    eb[1] = trans_d[7:0];
    eb[2] = 8'h00;
    eb[3] = 8'h00;
    if (ex_on) begin
      eb[4] = 8'h00;
      eb[5] = 8'h03;
      eb[6] = unit_d;
      eb[7] = ex_fc | mtrh_pkg::EX_FLAG;
      eb[8] = ex_code;
    end else begin
      eb[4] = lf[15:8];
      eb[5] = lf[7:0];
      eb[6] = unit_d;
      eb[7] = mtrh_pkg::FN_READ;
      eb[8] = {pend_q, 1'b0};
    end
    if (ex_on || hdr_on) begin
      for (int i = 0; i < 9; i++) begin
        job_o.data[base + 4'(i)] = eb[i];
      end
      job_o.last[base + 4'd8] = ex_on;
    end
    job_o.nbytes     = base + ((ex_on || hdr_on) ? 4'd9 : 4'd0);
    job_o.has_req    = req_on;
    job_o.start      = {hdr_w[8], hdr_w[9]};
    job_o.count      = cnt[6:0];
    job_o.requests   = req_d;
    job_o.responses  = resp_d;
    job_o.exceptions = exc_d;
    job_o.malformed  = mal_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      head_q    <= '0;
      phase_q   <= mtrh_pkg::PH_IDLE;
      trans_q   <= '0;
      unit_q    <= '0;
      pend_q    <= '0;
      left_q    <= '0;
      req_q     <= '0;
      resp_q    <= '0;
      exc_q     <= '0;
      mal_q     <= '0;
      rd_idx_q  <= '0;
      ref_tot_q <= '0;
      rsp_q     <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      head_q    <= head_d;
      phase_q   <= phase_d;
      trans_q   <= trans_d;
      unit_q    <= unit_d;
      pend_q    <= pend_d;
      left_q    <= left_d;
      req_q     <= req_d;
      resp_q    <= resp_d;
      exc_q     <= exc_d;
      mal_q     <= mal_d;
      rd_idx_q  <= rd_idx_d;
      ref_tot_q <= ref_tot_d;
      rsp_q     <= rsp_d;
    end
  end

  // header shadow and refill slot
  always_ff @(posedge clk_i) begin
    hdr_q  <= hdr_d;
    slot_q <= slot_d;
  end

endmodule

// File: src/mtrh_emit.sv
// result emitter: walks one job into the output register
module mtrh_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  mtrh_pkg::job_t job_i,
  output logic           busy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           kind_o,
  output logic [7:0]     out_byte_o,
  output logic           last_o,
  output logic [15:0]    read_start_o,
  output logic [6:0]     read_count_o,
  output logic [15:0]    requests_seen_o,
  output logic [15:0]    responses_made_o,
  output logic [15:0]    exceptions_made_o,
  output logic [15:0]    malformed_seen_o
);

  mtrh_pkg::job_t job_q;
  logic [3:0] idx_q, idx_d, total_q, total_d;
  logic       valid_q, valid_d, take;
  logic       kind_q, kind_d, last_q, last_d;
  logic [7:0] byte_q, byte_d;
  logic [15:0] start_q, start_d;
  logic [6:0]  count_q, count_d;
  logic [15:0] reqs_q, reqs_d, resps_q, resps_d, excs_q, excs_d, mals_q, mals_d;

  assign busy_o = (idx_q != total_q);
  assign take   = !valid_q || !out_stall_i;

  // next output transaction
  always_comb begin
    idx_d   = idx_q;
    total_d = total_q;
    valid_d = valid_q;
    kind_d  = kind_q;
    last_d  = last_q;
    byte_d  = byte_q;
    start_d = start_q;
    count_d = count_q;
    reqs_d  = reqs_q;
    resps_d = resps_q;
    excs_d  = excs_q;
    mals_d  = mals_q;
    if (take) begin
      if (idx_q != total_q) begin
        valid_d = 1'b1;
        idx_d   = idx_q + 4'd1;
        reqs_d  = job_q.requests;
        resps_d = job_q.responses;
        excs_d  = job_q.exceptions;
        mals_d  = job_q.malformed;
        if (idx_q < job_q.nbytes) begin
          kind_d  = 1'b0;
          byte_d  = job_q.data[idx_q];
          last_d  = job_q.last[idx_q];
          start_d = 16'h0;
          count_d = 7'h0;
        end else begin
          kind_d  = 1'b1;
          byte_d  = 8'h00;
          last_d  = 1'b0;
          start_d = job_q.start;
          count_d = job_q.count;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
    if (load_i) begin
      idx_d   = '0;
      total_d = job_i.nbytes + 4'(job_i.has_req);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      total_q <= total_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    last_q  <= last_d;
    byte_q  <= byte_d;
    start_q <= start_d;
    count_q <= count_d;
    reqs_q  <= reqs_d;
    resps_q <= resps_d;
    excs_q  <= excs_d;
    mals_q  <= mals_d;
    if (load_i) begin
      job_q <= job_i;
    end
  end

  assign out_valid_o       = valid_q;
  assign kind_o            = kind_q;
  assign out_byte_o        = byte_q;
  assign last_o            = last_q;
  assign read_start_o      = start_q;
  assign read_count_o      = count_q;
  assign requests_seen_o   = reqs_q;
  assign responses_made_o  = resps_q;
  assign exceptions_made_o = excs_q;
  assign malformed_seen_o  = mals_q;

endmodule

// File: src/modbus_tcp_read_holding_server.sv
// modbus tcp read holding registers server, top level
// results of a transaction pass the job register, then the single output
//   register, one per cycle while out_stall_i is low; the input stalls until
//   the job is walked, so a transaction with no result is taken every cycle
//   unless a reload stalls; a frame drop that leaves bytes behind reloads up
//   to 12 header bytes from the ring ram, one per cycle, stalling the input
// reset clears fill, head, phase and counters; the ring ram is not cleared
module modbus_tcp_read_holding_server #(
  parameter int AduBytes = mtrh_pkg::AduBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  status_code_i,
  input  logic [15:0] reg_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [15:0] read_start_o,
  output logic [6:0]  read_count_o,
  output logic [15:0] requests_seen_o,
  output logic [15:0] responses_made_o,
  output logic [15:0] exceptions_made_o,
  output logic [15:0] malformed_seen_o
);

  localparam int PtrW = $clog2(AduBytes);

  logic            accept, refill_busy, emit_busy, ram_we;
  logic [PtrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;
  mtrh_pkg::job_t  job;

  assign in_stall_o = refill_busy || emit_busy;
  assign accept     = in_valid_i && !in_stall_o;

  // receive ring
  mtrh_ram #(
    .Width (8),
    .Depth (AduBytes)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mtrh_ctrl #(
    .AduBytes (AduBytes)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .func_i        (func_i),
    .rx_byte_i     (rx_byte_i),
    .status_code_i (status_code_i),
    .reg_value_i   (reg_value_i),
    .refill_busy_o (refill_busy),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .job_o         (job)
  );

  mtrh_emit u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (accept),
    .job_i             (job),
    .busy_o            (emit_busy),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .out_byte_o        (out_byte_o),
    .last_o            (last_o),
    .read_start_o      (read_start_o),
    .read_count_o      (read_count_o),
    .requests_seen_o   (requests_seen_o),
    .responses_made_o  (responses_made_o),
    .exceptions_made_o (exceptions_made_o),
    .malformed_seen_o  (malformed_seen_o)
  );

endmodule
